[sv/bounded_sequence_store_core_macros.svh]
// ----------------------------------------------------------------------------
// bounded_sequence_store_core_macros
// Assertion macros used by the bounded sequence store sequencer (bss_seq).
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_STORE_CORE_MACROS_SVH
`define BOUNDED_SEQUENCE_STORE_CORE_MACROS_SVH

// same-cycle implication
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Types, codes and sizing constants of the bounded sequence store.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ADDR_MAX_W   = 12;  // enough for the largest capacity
  localparam int WIDE_W       = 13;  // holds any count or position

  localparam logic [3:0] KIND_PUSH_FRONT = 4'd0;
  localparam logic [3:0] KIND_PUSH_BACK  = 4'd1;
  localparam logic [3:0] KIND_POP_FRONT  = 4'd2;
  localparam logic [3:0] KIND_POP_BACK   = 4'd3;
  localparam logic [3:0] KIND_INSERT     = 4'd4;
  localparam logic [3:0] KIND_DEL_INDEX  = 4'd5;
  localparam logic [3:0] KIND_DEL_VALUE  = 4'd6;
  localparam logic [3:0] KIND_READ       = 4'd7;
  localparam logic [3:0] KIND_SEARCH     = 4'd8;
  localparam logic [3:0] KIND_REVERSE    = 4'd9;
  localparam logic [3:0] KIND_PALINDROME = 4'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADIDX   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [3:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic               match_flag;
    logic [6:0]         element_count;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [31:0]           wdata;
    logic                  re;
    logic [ADDR_MAX_W-1:0] raddr;
  } mem_req_t;

endpackage

[sv/bounded_sequence_store_core.sv]
// Ops that only set a status (full, empty, bad index, unused kinds, reverse/palindrome
// on fewer than two elements) go straight to the result; push back, pop back and read
// pass a single state (S_UP_RD, S_DN_RD or S_RD_WAIT); shifts, scans, reverse and
// palindrome walk the elements. One transaction at a time, the next taken in the cycle
// after the result strobe; each element moved takes a memory read and then a write.
// Reset empties the store (count 0); memory is not cleared. Receiver cannot stall.
// ----------------------------------------------------------------------------
// bounded_sequence_store_core
// Ordered store of signed 32-bit values with list, search and reverse ops.
// ----------------------------------------------------------------------------
module bounded_sequence_store_core import bss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  mem_req_t    mem_req;
  logic [31:0] mem_rdata;

  bss_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bss_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[sv/bss_mem.sv]
// ----------------------------------------------------------------------------
// bss_mem
// Element storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bss_mem import bss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);

  localparam int AW = $clog2(CAPACITY);

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bss_seq.sv]
// ----------------------------------------------------------------------------
// bss_seq
// Operation sequencer: decodes a command and walks the element memory.
// ----------------------------------------------------------------------------
module bss_seq import bss_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_item,
  output mem_req_t    mem_req,
  input  logic [31:0] mem_rdata
);

  `include "bounded_sequence_store_core_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_SCAN_RD, S_SCAN_CMP,
    S_RD_WAIT, S_REV_RDLO, S_REV_RDHI, S_REV_WRLO, S_REV_WRHI,
    S_PAL_RDLO, S_PAL_RDHI, S_PAL_CMP, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] rd_r, rd_nxt;
  logic        match_r, match_nxt;

  logic [WIDE_W-1:0] cnt_w, pos_w, idx_w, hi_w;
  logic              full;

  function automatic logic [ADDR_MAX_W-1:0] to_addr(input logic [CW-1:0] x);
    to_addr = ADDR_MAX_W'(x[AW-1:0]);
  endfunction

  assign cnt_w = WIDE_W'(cnt_r);
  assign pos_w = WIDE_W'(in_item.position);
  assign idx_w = WIDE_W'(idx_r);
  assign hi_w  = WIDE_W'(hi_r);
  assign full  = (cnt_w >= WIDE_W'(CAPACITY));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    hi_nxt     = hi_r;
    val_nxt    = val_r;
    hold_nxt   = hold_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    match_nxt  = match_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_item.kind;
          val_nxt    = in_item.item_value;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          match_nxt  = 1'b0;
          idx_nxt    = '0;
          hi_nxt     = '0;
          state_nxt  = S_DONE;
          case (in_item.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = cnt_r;
                hi_nxt    = (in_item.kind == KIND_PUSH_FRONT) ? '0 : cnt_r;
                state_nxt = S_UP_RD;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = (in_item.kind == KIND_POP_FRONT) ? '0 : cnt_r - 1'b1;
                state_nxt = S_DN_RD;
              end
            end
            KIND_INSERT: begin
              if (pos_w > cnt_w) begin
                status_nxt = ST_BADIDX;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = cnt_r;
                hi_nxt    = CW'(in_item.position);
                state_nxt = S_UP_RD;
              end
            end
            KIND_DEL_INDEX: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (pos_w >= cnt_w) begin
                status_nxt = ST_BADIDX;
              end else begin
                idx_nxt   = CW'(in_item.position);
                state_nxt = S_DN_RD;
              end
            end
            KIND_DEL_VALUE: begin
              status_nxt = ST_NOTFOUND;
              state_nxt  = S_SCAN_RD;
            end
            KIND_READ: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_BADIDX;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = to_addr(CW'(in_item.position));
                state_nxt     = S_RD_WAIT;
              end
            end
            KIND_SEARCH: begin
              state_nxt = S_SCAN_RD;
            end
            KIND_REVERSE: begin
              if (cnt_w > WIDE_W'(1)) begin
                hi_nxt    = cnt_r - 1'b1;
                state_nxt = S_REV_RDLO;
              end
            end
            KIND_PALINDROME: begin
              match_nxt = 1'b1;
              if (cnt_w > WIDE_W'(1)) begin
                hi_nxt    = cnt_r - 1'b1;
                state_nxt = S_PAL_RDLO;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // open a gap: move elements up from the back, then drop the new value in
      S_UP_RD: begin
        if (idx_r > hi_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = to_addr(idx_r - 1'b1);
          state_nxt     = S_UP_WR;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = to_addr(hi_r);
          mem_req.wdata = val_r;
          cnt_nxt       = cnt_r + 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_UP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = to_addr(idx_r);
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_r - 1'b1;
        state_nxt     = S_UP_RD;
      end
      // close a gap: move elements down toward the front
      S_DN_RD: begin
        if (idx_w + WIDE_W'(1) < cnt_w) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = to_addr(idx_r + 1'b1);
          state_nxt     = S_DN_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = to_addr(idx_r);
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_r + 1'b1;
        state_nxt     = S_DN_RD;
      end
      S_SCAN_RD: begin
        if (idx_r < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = to_addr(idx_r);
          state_nxt     = S_SCAN_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN_CMP: begin
        if (mem_rdata == val_r) begin
          if (op_r == KIND_DEL_VALUE) begin
            status_nxt = ST_OK;
            state_nxt  = S_DN_RD;
          end else begin
            match_nxt = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_RD_WAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_DONE;
      end
      S_REV_RDLO: begin
        if (idx_w < hi_w) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = to_addr(idx_r);
          state_nxt     = S_REV_RDHI;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_REV_RDHI: begin
        hold_nxt      = mem_rdata;
        mem_req.re    = 1'b1;
        mem_req.raddr = to_addr(hi_r);
        state_nxt     = S_REV_WRLO;
      end
      S_REV_WRLO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = to_addr(idx_r);
        mem_req.wdata = mem_rdata;
        state_nxt     = S_REV_WRHI;
      end
      S_REV_WRHI: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = to_addr(hi_r);
        mem_req.wdata = hold_r;
        idx_nxt       = idx_r + 1'b1;
        hi_nxt        = hi_r - 1'b1;
        state_nxt     = S_REV_RDLO;
      end
      S_PAL_RDLO: begin
        if (idx_w < hi_w) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = to_addr(idx_r);
          state_nxt     = S_PAL_RDHI;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PAL_RDHI: begin
        hold_nxt      = mem_rdata;
        mem_req.re    = 1'b1;
        mem_req.raddr = to_addr(hi_r);
        state_nxt     = S_PAL_CMP;
      end
      S_PAL_CMP: begin
        if (mem_rdata != hold_r) begin
          match_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          hi_nxt    = hi_r - 1'b1;
          state_nxt = S_PAL_RDLO;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    hi_r     <= hi_nxt;
    val_r    <= val_nxt;
    hold_r   <= hold_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    match_r  <= match_nxt;
  end

  assign busy                   = (state_r != S_IDLE);
  assign out_valid              = (state_r == S_DONE);
  assign out_item.status        = status_r;
  assign out_item.read_value    = rd_r;
  assign out_item.match_flag    = match_r;
  assign out_item.element_count = 7'(cnt_r);

  `BSS_ASSERT_NOW(a_cnt_bound, 1'b1, WIDE_W'(cnt_r) <= WIDE_W'(CAPACITY), "count above capacity")
  `BSS_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid, "result strobe longer than a cycle")
  `BSS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction not taken up")
  `BSS_ASSERT_NOW(a_no_rw_clash, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "read and write hit the same entry")

endmodule
